// ===== sv/aes128_cmac_engine_macros.svh =====
// assertion helpers shared by the engine
`ifndef AES128_CMAC_ENGINE_MACROS_SVH
`define AES128_CMAC_ENGINE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CMAC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmac implication check failed");

// next-cycle implication, checked out of reset
`define CMAC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmac next-cycle check failed");

`endif

// ===== sv/aescm_pkg.sv =====
package aescm_pkg;

	localparam int NumRounds = 10;
	localparam int RndW      = 4;

	localparam logic [1:0] RegKeyHigh = 2'd0;
	localparam logic [1:0] RegKeyLow  = 2'd1;

	typedef enum logic [1:0] {
		BK_MSG,
		BK_FULL,
		BK_PART
	} blk_kind_t;

	typedef struct packed {
		logic [127:0] blk;
		blk_kind_t    kind;
	} q_entry_t;

	typedef enum logic [1:0] {
		ST_KEXP,
		ST_KENC,
		ST_IDLE,
		ST_RUN
	} bk_state_t;

	typedef struct packed {
		logic            key_busy;
		logic [RndW-1:0] rnd;
	} bk_status_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] RCON [11] = '{
		8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [127:0] DblPoly = 128'h87;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// one full round: sub bytes, shift rows, mix columns unless last, add key
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
			input logic last);
		logic [7:0] t [16];
		logic [7:0] u [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			t[i] = SBOX[s[127-8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				u[i+4*c] = t[i + 4*((c+i) % 4)];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				u[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				u[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				u[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				u[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127-8*i -: 8] = u[i];
		end
		return r ^ k;
	endfunction

	// next round key from the previous one
	function automatic logic [127:0] key_next(input logic [127:0] p, input logic [RndW-1:0] n);
		logic [31:0] t, w4, w5, w6, w7;
		t  = {SBOX[p[23:16]] ^ RCON[n], SBOX[p[15:8]], SBOX[p[7:0]], SBOX[p[31:24]]};
		w4 = p[127:96] ^ t;
		w5 = p[95:64] ^ w4;
		w6 = p[63:32] ^ w5;
		w7 = p[31:0] ^ w6;
		return {w4, w5, w6, w7};
	endfunction

	function automatic logic [127:0] dbl(input logic [127:0] x);
		return {x[126:0], 1'b0} ^ (x[127] ? DblPoly : '0);
	endfunction

endpackage

// ===== sv/aescm_front.sv =====
module aescm_front import aescm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [127:0] in_blk,
	input  logic [4:0]   in_count,
	input  logic         in_last,
	output logic         q_valid,
	input  logic         q_ready,
	output q_entry_t     q_data
);

	q_entry_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	q_entry_t   ent;
	logic       push, pop;

	// pad a short final block: 0x80 at the count, zeros past it
	always_comb begin
		ent.blk  = in_blk;
		ent.kind = BK_MSG;
		if (in_last) begin
			if (in_count >= 5'd16) begin
				ent.kind = BK_FULL;
			end else begin
				ent.kind = BK_PART;
				for (int i = 0; i < 16; i++) begin
					if (5'(i) == in_count) begin
						ent.blk[127-8*i -: 8] = 8'h80;
					end else if (5'(i) > in_count) begin
						ent.blk[127-8*i -: 8] = 8'h00;
					end
				end
			end
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/aescm_back.sv =====
module aescm_back import aescm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [63:0]  cfg_wdata,
	input  logic         q_valid,
	output logic         q_ready,
	input  q_entry_t     q_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [127:0] out_mac,
	output bk_status_t   status
);

	bk_state_t       state_q, state_d;
	logic [127:0]    key_q, kx_q, st_q, chain_q, k1_q, k2_q, mac_q;
	logic [127:0]    rk_q [NumRounds+1];
	logic [127:0]    rnd_out, kx_nxt, blk, new_key;
	logic [RndW-1:0] rnd_q, kcnt_q;
	logic            fin_q, outv_q, key_wr, start, last_rnd;

	assign key_wr   = cfg_we && (cfg_idx == RegKeyHigh || cfg_idx == RegKeyLow);
	assign new_key  = (cfg_idx == RegKeyHigh) ? {cfg_wdata, key_q[63:0]}
	                                          : {key_q[127:64], cfg_wdata};
	assign last_rnd = (rnd_q == RndW'(NumRounds));
	assign rnd_out  = aes_round(st_q, rk_q[rnd_q], last_rnd);
	assign kx_nxt   = key_next(kx_q, kcnt_q);
	assign q_ready  = (state_q == ST_IDLE) && !(q_data.kind != BK_MSG && outv_q);
	assign start    = q_valid && q_ready;

	always_comb begin
		case (q_data.kind)
			BK_FULL: blk = q_data.blk ^ k1_q;
			BK_PART: blk = q_data.blk ^ k2_q;
			default: blk = q_data.blk;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_KEXP: if (kcnt_q == RndW'(NumRounds)) state_d = ST_KENC;
			ST_KENC: if (last_rnd) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_RUN;
			ST_RUN:  if (last_rnd) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (key_wr) state_d = ST_KEXP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KEXP;
			key_q   <= '0;
			kx_q    <= '0;
			kcnt_q  <= RndW'(1);
			rnd_q   <= RndW'(1);
			chain_q <= '0;
			outv_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ready) outv_q <= 1'b0;
			if (key_wr) begin
				key_q  <= new_key;
				kx_q   <= new_key;
				kcnt_q <= RndW'(1);
			end else begin
				case (state_q)
					ST_KEXP: begin
						kx_q   <= kx_nxt;
						kcnt_q <= kcnt_q + RndW'(1);
						rnd_q  <= RndW'(1);
					end
					ST_KENC, ST_RUN: begin
						rnd_q <= rnd_q + RndW'(1);
						if (last_rnd && state_q == ST_RUN) begin
							if (fin_q) begin
								outv_q  <= 1'b1;
								chain_q <= '0;
							end else begin
								chain_q <= rnd_out;
							end
						end
					end
					ST_IDLE: begin
						if (start) begin
							rnd_q <= RndW'(1);
							fin_q <= (q_data.kind != BK_MSG);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (key_wr) begin
			rk_q[0] <= new_key;
		end else begin
			case (state_q)
				ST_KEXP: begin
					rk_q[kcnt_q] <= kx_nxt;
					rk_q[0]      <= key_q;
					st_q         <= rk_q[0];
				end
				ST_KENC, ST_RUN: begin
					st_q <= rnd_out;
					if (last_rnd && state_q == ST_KENC) begin
						k1_q <= dbl(rnd_out);
						k2_q <= dbl(dbl(rnd_out));
					end
					if (last_rnd && state_q == ST_RUN && fin_q) begin
						mac_q <= rnd_out;
					end
				end
				ST_IDLE: if (start) st_q <= chain_q ^ blk ^ rk_q[0];
				default: ;
			endcase
		end
	end

	assign out_valid       = outv_q;
	assign out_mac         = mac_q;
	assign status.key_busy = (state_q == ST_KEXP) || (state_q == ST_KENC);
	assign status.rnd      = rnd_q;

endmodule

// ===== sv/aes128_cmac_engine.sv =====
// aes-128 cmac engine
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 writes
// key bytes 0..7, index 1 key bytes 8..15, other indexes are ignored. every key
// write expands the round keys and derives the subkeys from the encryption of the
// zero block. the user must make writes only while idle; the block does not enforce it.
// message channel: s_tvalid/s_tready, one 16-byte block per request, s_tlast
// marks the final block, whose byte count selects full or padded handling.
// mac channel: m_tvalid/m_tready carries the 128-bit tag after each final block.
// each block takes a load step and then ten rounds of the single shared round
// unit; cbc chaining serializes blocks through that unit, so a new block is
// taken only after the last one is through. a final block's tag is registered
// at the end of its last round.
// a two-entry queue in front takes requests while the round unit is busy.
// reset: key becomes zero and subkey derivation starts at once (no blocks are
// processed meanwhile); chaining value is zero.
// when the mac receiver stalls the tag holds; non-final blocks keep flowing and
// the next final block waits until the tag has gone.
module aes128_cmac_engine import aescm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // block_high, block_low, byte_count, zero fill
	input  logic         s_tlast,   // final_block
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // mac_high, mac_low
);

	logic         q_valid, q_ready;
	q_entry_t     q_data;
	logic [127:0] mac;
	bk_status_t   status;

	assign cfg_ready = 1'b1;

	// front: classify and pad, then queue
	aescm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_blk   ({s_tdata[63:0], s_tdata[127:64]}),
		.in_count (s_tdata[132:128]),
		.in_last  (s_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	// back: key schedule, round unit, chaining and tag register
	aescm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_mac   (mac),
		.status    (status)
	);

	assign m_tdata = {mac[63:0], mac[127:64]};

`include "aes128_cmac_engine_macros.svh"

	// round counter never runs more than one past the last round
	`CMAC_ASSERT_IMP(a_rnd_bound, 1'b1, status.rnd <= RndW'(NumRounds + 1))
	// no block is taken from the queue during key derivation
	`CMAC_ASSERT_IMP(a_no_start_busy, status.key_busy, !q_ready)
	// a tag never appears straight out of key derivation
	`CMAC_ASSERT_NXT(a_no_tag_busy, status.key_busy && !m_tvalid, !m_tvalid)

endmodule

// ===== tb/cmac_checker.sv =====
`timescale 1ns / 1ps

module cmac_checker import aescm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           errors,
	output int           pending,
	output int           tags_seen
);

	typedef struct packed {
		logic [63:0] mac_high;
		logic [63:0] mac_low;
	} tag_t;

	logic [63:0]  key_hi, key_lo;
	logic [127:0] chain;
	logic [127:0] rkey [11];
	logic [127:0] sub1, sub2;
	tag_t         tag_q [$];

	function automatic logic [7:0] gmul2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] cipher(input logic [127:0] pt);
		logic [7:0] t [16];
		logic [7:0] u [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] s;
		s = pt ^ rkey[0];
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++)
				t[i] = SBOX[s[127-8*i -: 8]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					u[i+4*c] = t[i + 4*((c+i) % 4)];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					u[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
					u[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
					u[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
					u[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				s[127-8*i -: 8] = u[i];
			s = s ^ rkey[r];
		end
		return s;
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] x);
		return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
	endfunction

	// key schedule and subkeys from the current key registers
	task automatic rekey();
		logic [31:0] w [44];
		logic [31:0] p, t;
		logic [127:0] l;
		w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
		w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
		for (int i = 4; i < 44; i++) begin
			p = w[i-1];
			t = p;
			if (i % 4 == 0)
				t = {SBOX[p[23:16]] ^ RCON[i/4], SBOX[p[15:8]], SBOX[p[7:0]], SBOX[p[31:24]]};
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++)
			rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		l = cipher(128'h0);
		sub1 = gf_double(l);
		sub2 = gf_double(sub1);
	endtask

	// absorb one block; returns 1 with the tag when it was the final one
	function automatic logic absorb(input logic [127:0] blk, input logic [4:0] cnt,
			input logic fin, output tag_t tag);
		logic [127:0] x;
		x = blk;
		if (fin) begin
			if (cnt >= 16) begin
				x = x ^ sub1;
			end else begin
				for (int i = 0; i < 16; i++)
					if (i >= cnt)
						x[127-8*i -: 8] = (i == cnt) ? 8'h80 : 8'h00;
				x = x ^ sub2;
			end
		end
		chain = cipher(chain ^ x);
		tag = chain;
		if (fin)
			chain = '0;
		return fin;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tag_t exp_t, got_t;
		if (!arst_n) begin
			key_hi = '0;
			key_lo = '0;
			chain  = '0;
			rekey();
			tag_q.delete();
			errors    = 0;
			tags_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegKeyHigh) begin
					key_hi = cfg_data;
					rekey();
				end else if (cfg_index == RegKeyLow) begin
					key_lo = cfg_data;
					rekey();
				end
			end
			if (s_tvalid && s_tready) begin
				if (absorb({s_tdata[63:0], s_tdata[127:64]}, s_tdata[132:128], s_tlast, exp_t))
					tag_q.push_back(exp_t);
			end
			if (m_tvalid && m_tready) begin
				got_t.mac_high = m_tdata[63:0];
				got_t.mac_low  = m_tdata[127:64];
				tags_seen++;
				if (tag_q.size() == 0) begin
					$error("unexpected tag %h%h", got_t.mac_high, got_t.mac_low);
					errors++;
				end else begin
					exp_t = tag_q.pop_front();
					if (got_t.mac_high !== exp_t.mac_high) begin
						$error("mac_high expected %h got %h", exp_t.mac_high, got_t.mac_high);
						errors++;
					end
					if (got_t.mac_low !== exp_t.mac_low) begin
						$error("mac_low expected %h got %h", exp_t.mac_low, got_t.mac_low);
						errors++;
					end
				end
			end
		end
		pending = tag_q.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import aescm_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;   // block_high, block_low, byte_count, zero fill
	logic         s_tlast;   // final_block
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // mac_high, mac_low

	int errors, pending, tags_seen;
	int blocks_sent, msgs_sent, key_loads;
	// the receiver counts its own long hold-offs against these requests
	int hold_asks;

	aes128_cmac_engine i_dut (.*);

	cmac_checker i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// limit on the whole run
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// mac receiver: random stalls, quiet stretches, and long hold-offs on request
	initial begin
		int hold_left, free_run, done_asks, r;
		hold_left = 0;
		free_run  = 0;
		done_asks = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (done_asks < hold_asks) begin
				done_asks++;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (free_run > 0) begin
				free_run--;
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					free_run = $urandom_range(50, 200);
				else if (r < 5)
					hold_left = $urandom_range(10, 40);
				m_tready <= (r >= 25);
			end
		end
	end

	// idle cycles between requests: mostly none, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		key_loads++;
		@(posedge clk);
	endtask

	// one block request; valid stays high into the next one when no gap follows
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
			input logic [4:0] cnt, input logic fin);
		int g;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cnt, lo, hi};
		s_tlast  <= fin;
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		blocks_sent++;
		if (fin)
			msgs_sent++;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// random message: up to four absorbed blocks, then the final one
	task automatic send_message();
		int n, r;
		logic [4:0] cnt;
		n = $urandom_range(0, 4);
		repeat (n) send_block(rnd64(), rnd64(), 5'($urandom_range(0, 31)), 1'b0);
		r = $urandom_range(0, 99);
		if (r < 35)
			cnt = 5'd16;
		else if (r < 45)
			cnt = 5'd0;
		else
			cnt = 5'($urandom_range(0, 31));
		send_block(rnd64(), rnd64(), cnt, 1'b1);
	endtask

	// sender waits until every tag is back, then lets the core drain
	task automatic drain();
		s_tvalid <= 1'b0;
		forever begin
			@(negedge clk);
			if (pending == 0) break;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic random_phase(input int n_blocks);
		int start;
		start = blocks_sent;
		while (blocks_sent - start < n_blocks)
			send_message();
		drain();
	endtask

	initial begin
		cfg_valid   = 1'b0;
		cfg_index   = RegKeyHigh;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		hold_asks   = 0;
		blocks_sent = 0;
		msgs_sent   = 0;
		key_loads   = 0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset key (all zero)
		send_block('0, '0, 5'd0, 1'b1);                    // empty message
		send_block('1, '1, 5'd16, 1'b1);                   // full final block
		send_block('1, '1, 5'd31, 1'b1);                   // oversized count
		send_block('1, '1, 5'd1, 1'b1);                    // bytes past count dropped
		send_block('1, '1, 5'd15, 1'b1);
		send_block(rnd64(), rnd64(), 5'd0, 1'b0);          // count ignored when not final
		send_block(rnd64(), rnd64(), 5'd17, 1'b0);
		send_block(rnd64(), rnd64(), 5'd8, 1'b1);
		drain();

		// extremes of the key
		write_key(RegKeyHigh, '1);
		write_key(RegKeyLow, '1);
		send_block('0, '0, 5'd16, 1'b1);
		send_block('1, '0, 5'd7, 1'b1);
		send_block('0, '1, 5'd0, 1'b1);
		// long receiver hold-off while blocks keep coming, so the input backs up
		hold_asks++;
		random_phase(150);

		// standard test key, writes to unused indexes are ignored
		write_key(RegKeyHigh, 64'h2b7e151628aed2a6);
		write_key(RegKeyLow, 64'habf7158809cf4f3c);
		write_key(2'd2, '1);
		write_key(2'd3, rnd64());
		send_block('0, '0, 5'd0, 1'b1);
		send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
		random_phase(150);

		// key changed with a message still open: chaining value carries over
		send_block(rnd64(), rnd64(), 5'd16, 1'b0);
		drain();
		write_key(RegKeyLow, '0);
		send_block(rnd64(), rnd64(), 5'd4, 1'b1);
		random_phase(150);

		repeat (3) begin
			write_key(RegKeyHigh, rnd64());
			write_key(RegKeyLow, rnd64());
			random_phase(140);
		end

		hold_asks++;
		random_phase(60);

		$display("covered %0d blocks in %0d messages, %0d tags checked, %0d key writes",
			blocks_sent, msgs_sent, tags_seen, key_loads);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
